@@ design/qpr_pkg.sv @@
`timescale 1ns / 1ps
// Quaternion point rotation: shared widths, word types and register indexes.
// No dependencies; imported by every module of the block.
package qpr_pkg;

    localparam int COORD_WIDTH    = 32;
    localparam int QUAT_FRAC_BITS = 14;
    localparam int QUAT_WIDTH     = 16;

    // first Hamilton product: q component times coordinate, sum of three
    localparam int P1_W = QUAT_WIDTH + COORD_WIDTH;
    localparam int S1_W = P1_W + 2;
    localparam int T_W  = S1_W - QUAT_FRAC_BITS;
    // second Hamilton product: t part times q component, sum of four
    localparam int P2_W = T_W + QUAT_WIDTH;
    localparam int S2_W = P2_W + 2;
    localparam int R_W  = S2_W - QUAT_FRAC_BITS;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = QUAT_WIDTH;

    localparam logic [CFG_ADDR_W-1:0] CFG_QUAT_W = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_QUAT_X = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] CFG_QUAT_Y = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] CFG_QUAT_Z = CFG_ADDR_W'(3);

    localparam logic signed [QUAT_WIDTH-1:0] QUAT_ONE =
        QUAT_WIDTH'(64'd1 << QUAT_FRAC_BITS);

    localparam logic signed [S1_W-1:0] RND1 = S1_W'(1) << (QUAT_FRAC_BITS - 1);
    localparam logic signed [S2_W-1:0] RND2 = S2_W'(1) << (QUAT_FRAC_BITS - 1);

    localparam logic signed [COORD_WIDTH-1:0] ROT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] ROT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic signed [R_W-1:0] R_MAX = R_W'(ROT_MAX);
    localparam logic signed [R_W-1:0] R_MIN = R_W'(ROT_MIN);

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] point_z;
    } t_point_word;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] rot_x;
        logic signed [COORD_WIDTH-1:0] rot_y;
        logic signed [COORD_WIDTH-1:0] rot_z;
        logic                          saturated;
    } t_rot_word;

    typedef struct packed {
        logic signed [QUAT_WIDTH-1:0] w;
        logic signed [QUAT_WIDTH-1:0] x;
        logic signed [QUAT_WIDTH-1:0] y;
        logic signed [QUAT_WIDTH-1:0] z;
    } t_quat;

endpackage

@@ design/qpr_sat.sv @@
`timescale 1ns / 1ps
// Clips the three rounded result parts to the coordinate range and flags it.
// Depends on qpr_pkg.
module qpr_sat import qpr_pkg::*; (
    input  logic signed [R_W-1:0] i_rx,
    input  logic signed [R_W-1:0] i_ry,
    input  logic signed [R_W-1:0] i_rz,
    output t_rot_word             o_word
);

    logic hi_x, lo_x, hi_y, lo_y, hi_z, lo_z;

    always_comb begin
        hi_x = i_rx > R_MAX;
        lo_x = i_rx < R_MIN;
        hi_y = i_ry > R_MAX;
        lo_y = i_ry < R_MIN;
        hi_z = i_rz > R_MAX;
        lo_z = i_rz < R_MIN;

        o_word.rot_x = hi_x ? ROT_MAX : (lo_x ? ROT_MIN : i_rx[COORD_WIDTH-1:0]);
        o_word.rot_y = hi_y ? ROT_MAX : (lo_y ? ROT_MIN : i_ry[COORD_WIDTH-1:0]);
        o_word.rot_z = hi_z ? ROT_MAX : (lo_z ? ROT_MIN : i_rz[COORD_WIDTH-1:0]);
        o_word.saturated = hi_x | lo_x | hi_y | lo_y | hi_z | lo_z;
    end

endmodule

@@ design/quaternion_point_rotation_core.sv @@
`timescale 1ns / 1ps
// Quaternion point rotation core: r = q * p * conj(q), fixed point, saturated.
// Depends on qpr_pkg and qpr_sat.
//
//  channel   direction  valid         stall         word
//  input     in         i_in_valid    o_in_stall    i_in_word  (t_point_word)
//  output    out        o_out_valid   i_out_stall   o_out_word (t_rot_word)
//  config    in         i_cfg_we      -             i_cfg_addr, i_cfg_wdata
//
// One point per cycle sustained while i_out_stall is low; the stages are products, round t,
// products, round r, and saturate into the output register.
// Each stage holds only while its successor is full and held, so bubbles close.
// Synchronous reset clears valid bits and sets q to the identity.
module quaternion_point_rotation_core import qpr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_point_word           i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_rot_word             o_out_word
);

    t_quat r_q;

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    logic signed [P1_W-1:0] r_p1 [12];
    logic signed [T_W-1:0]  r_tw, r_tx, r_ty, r_tz;
    logic signed [P2_W-1:0] r_p2 [12];
    logic signed [R_W-1:0]  r_rx, r_ry, r_rz;
    t_rot_word              r_out;

    logic signed [S1_W-1:0] n_sw, n_sx, n_sy, n_sz;
    logic signed [S2_W-1:0] n_sx2, n_sy2, n_sz2;
    t_rot_word              n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.w <= QUAT_ONE;
            r_q.x <= '0;
            r_q.y <= '0;
            r_q.z <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_QUAT_W: r_q.w <= signed'(i_cfg_wdata);
                CFG_QUAT_X: r_q.x <= signed'(i_cfg_wdata);
                CFG_QUAT_Y: r_q.y <= signed'(i_cfg_wdata);
                CFG_QUAT_Z: r_q.z <= signed'(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    always_comb begin
        rdy5 = !r_v5 || !i_out_stall;
        rdy4 = !r_v4 || rdy5;
        rdy3 = !r_v3 || rdy4;
        rdy2 = !r_v2 || rdy3;
        rdy1 = !r_v1 || rdy2;
    end

    assign o_in_stall = !rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_in_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
        end
    end

    // first product terms
    always_ff @(posedge i_clk) begin
        if (rdy1 && i_in_valid) begin
            r_p1[0]  <= r_q.x * i_in_word.point_x;
            r_p1[1]  <= r_q.y * i_in_word.point_y;
            r_p1[2]  <= r_q.z * i_in_word.point_z;
            r_p1[3]  <= r_q.w * i_in_word.point_x;
            r_p1[4]  <= r_q.y * i_in_word.point_z;
            r_p1[5]  <= r_q.z * i_in_word.point_y;
            r_p1[6]  <= r_q.w * i_in_word.point_y;
            r_p1[7]  <= r_q.z * i_in_word.point_x;
            r_p1[8]  <= r_q.x * i_in_word.point_z;
            r_p1[9]  <= r_q.w * i_in_word.point_z;
            r_p1[10] <= r_q.x * i_in_word.point_y;
            r_p1[11] <= r_q.y * i_in_word.point_x;
        end
    end

    always_comb begin
        n_sw = RND1 - S1_W'(r_p1[0]) - S1_W'(r_p1[1]) - S1_W'(r_p1[2]);
        n_sx = RND1 + S1_W'(r_p1[3]) + S1_W'(r_p1[4]) - S1_W'(r_p1[5]);
        n_sy = RND1 + S1_W'(r_p1[6]) + S1_W'(r_p1[7]) - S1_W'(r_p1[8]);
        n_sz = RND1 + S1_W'(r_p1[9]) + S1_W'(r_p1[10]) - S1_W'(r_p1[11]);
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r_tw <= T_W'(n_sw >>> QUAT_FRAC_BITS);
            r_tx <= T_W'(n_sx >>> QUAT_FRAC_BITS);
            r_ty <= T_W'(n_sy >>> QUAT_FRAC_BITS);
            r_tz <= T_W'(n_sz >>> QUAT_FRAC_BITS);
        end
    end

    // second product terms, against conj(q)
    always_ff @(posedge i_clk) begin
        if (rdy3 && r_v2) begin
            r_p2[0]  <= r_tw * r_q.x;
            r_p2[1]  <= r_tx * r_q.w;
            r_p2[2]  <= r_ty * r_q.z;
            r_p2[3]  <= r_tz * r_q.y;
            r_p2[4]  <= r_tw * r_q.y;
            r_p2[5]  <= r_ty * r_q.w;
            r_p2[6]  <= r_tz * r_q.x;
            r_p2[7]  <= r_tx * r_q.z;
            r_p2[8]  <= r_tw * r_q.z;
            r_p2[9]  <= r_tz * r_q.w;
            r_p2[10] <= r_tx * r_q.y;
            r_p2[11] <= r_ty * r_q.x;
        end
    end

    always_comb begin
        n_sx2 = RND2 - S2_W'(r_p2[0]) + S2_W'(r_p2[1]) - S2_W'(r_p2[2]) + S2_W'(r_p2[3]);
        n_sy2 = RND2 - S2_W'(r_p2[4]) + S2_W'(r_p2[5]) - S2_W'(r_p2[6]) + S2_W'(r_p2[7]);
        n_sz2 = RND2 - S2_W'(r_p2[8]) + S2_W'(r_p2[9]) - S2_W'(r_p2[10]) + S2_W'(r_p2[11]);
    end

    always_ff @(posedge i_clk) begin
        if (rdy4 && r_v3) begin
            r_rx <= R_W'(n_sx2 >>> QUAT_FRAC_BITS);
            r_ry <= R_W'(n_sy2 >>> QUAT_FRAC_BITS);
            r_rz <= R_W'(n_sz2 >>> QUAT_FRAC_BITS);
        end
    end

    qpr_sat u_sat (
        .i_rx   (r_rx),
        .i_ry   (r_ry),
        .i_rz   (r_rz),
        .o_word (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (rdy5 && r_v4) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_v5;
    assign o_out_word  = r_out;

endmodule

@@ design/qpr_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the quaternion point rotation core, bound to the top.
// Depends on qpr_pkg and quaternion_point_rotation_core.
module qpr_checker import qpr_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input t_rot_word             o_out_word
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("held output word changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output");

    a_sat_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.saturated |->
            (o_out_word.rot_x == ROT_MAX) || (o_out_word.rot_x == ROT_MIN) ||
            (o_out_word.rot_y == ROT_MAX) || (o_out_word.rot_y == ROT_MIN) ||
            (o_out_word.rot_z == ROT_MAX) || (o_out_word.rot_z == ROT_MIN))
        else $error("saturation flag without a clipped part");

endmodule

bind quaternion_point_rotation_core qpr_checker u_qpr_checker (.*);
